### rtl/tcd_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the text code point decoder.
// No dependencies.
package tcd_pkg;

  localparam int CpW = 21;

  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_UTF8   = 2'd1,
    MODE_UTF16B = 2'd2,
    MODE_UTF16L = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_CHAR     = 4'd0,
    ST_END      = 4'd1,
    ST_NULL     = 4'd2,
    ST_HIGHBYTE = 4'd3,
    ST_BADLEAD  = 4'd4,
    ST_BADCONT  = 4'd5,
    ST_U8SURR   = 4'd6,
    ST_TWOHIGH  = 4'd7,
    ST_LONELOW  = 4'd8,
    ST_MISSLOW  = 4'd9,
    ST_TRUNC    = 4'd10
  } status_t;

  // Decoder state carried between words
  typedef struct packed {
    logic [1:0]     bytes_rem;
    logic [CpW-1:0] partial;
    logic           fb_held;
    logic [7:0]     fb;
    logic           hh_pend;
    logic [9:0]     hh_bits;
    logic           after_cr;
    logic           halted;
  } dec_state_t;

  // Normalisation result for one complete code point
  typedef struct packed {
    logic           emit;
    logic           is_null;
    logic [CpW-1:0] cp;
    logic           after_cr;
  } norm_t;

endpackage

### rtl/tcd_norm.sv
`timescale 1ns / 1ps
// Normalisation of one complete code point: null check, CR/LF folding,
// Unicode space/dash mapping, zero-width drop. Depends on tcd_pkg.
module tcd_norm (
  input  logic [tcd_pkg::CpW-1:0] cp,
  input  logic                    after_cr,
  input  logic                    unicode,
  output tcd_pkg::norm_t          res
);

  typedef enum logic [1:0] {
    CLS_KEEP  = 2'd0,
    CLS_SPACE = 2'd1,
    CLS_DROP  = 2'd2
  } cls_t;

  function automatic cls_t classify(input logic [tcd_pkg::CpW-1:0] v);
    cls_t c;
    c = CLS_KEEP;
    case (v)
      21'h0000A0, 21'h001680, 21'h002000, 21'h002001, 21'h002002,
      21'h002003, 21'h002004, 21'h002005, 21'h002006, 21'h002007,
      21'h002008, 21'h00202F, 21'h00205F, 21'h002012, 21'h002013,
      21'h002014, 21'h002212, 21'h003000: c = CLS_SPACE;
      21'h0000AD, 21'h002009, 21'h00200A, 21'h00200B, 21'h00200C,
      21'h00200D, 21'h002060, 21'h00FEFF: c = CLS_DROP;
      default: c = CLS_KEEP;
    endcase
    return c;
  endfunction

  cls_t cls;

  always_comb begin
    cls          = unicode ? classify(cp) : CLS_KEEP;
    res.emit     = 1'b1;
    res.is_null  = 1'b0;
    res.cp       = cp;
    res.after_cr = after_cr;
    if (cp == '0) begin
      res.is_null = 1'b1;
      res.cp      = '0;
    end else begin
      res.after_cr = 1'b0;
      if (after_cr && cp == 21'h00000A) begin
        res.emit = 1'b0;
      end else if (cls == CLS_DROP) begin
        res.emit = 1'b0;
      end else begin
        if (cls == CLS_SPACE) begin
          res.cp = 21'h000020;
        end
        if (cp == 21'h00000D) begin
          res.after_cr = 1'b1;
          res.cp       = 21'h00000A;
        end
      end
    end
  end

endmodule

### rtl/tcd_decode.sv
`timescale 1ns / 1ps
// Single-pass decode of one word: UTF-8 / UTF-16 assembly, error checks,
// next state and result. Depends on tcd_pkg and tcd_norm.
module tcd_decode (
  input  tcd_pkg::mode_t          mode,
  input  tcd_pkg::dec_state_t     st,
  input  logic [7:0]              data_byte,
  input  logic                    eos,
  output tcd_pkg::dec_state_t     st_nxt,
  output logic                    res_valid,
  output logic [tcd_pkg::CpW-1:0] res_cp,
  output tcd_pkg::status_t        res_status
);

  tcd_pkg::dec_state_t    s;
  logic                   cand_valid;
  logic [tcd_pkg::CpW-1:0] cand_cp;
  logic                   err_valid;
  tcd_pkg::status_t       err_code;
  logic [tcd_pkg::CpW-1:0] pv;
  logic [15:0]            unit;
  tcd_pkg::norm_t         nres;

  tcd_norm u_norm (
    .cp       (cand_cp),
    .after_cr (st.after_cr),
    .unicode  (mode != tcd_pkg::MODE_RAW),
    .res      (nres)
  );

  always_comb begin
    s          = st;
    cand_valid = 1'b0;
    cand_cp    = '0;
    err_valid  = 1'b0;
    err_code   = tcd_pkg::ST_END;
    pv         = {st.partial[14:0], data_byte[5:0]};
    unit       = (mode == tcd_pkg::MODE_UTF16B) ? {st.fb, data_byte} : {data_byte, st.fb};
    if (st.halted) begin
      // hold
    end else if (eos) begin
      err_valid = 1'b1;
      if (st.bytes_rem != 2'd0 || st.fb_held || st.hh_pend) begin
        err_code = tcd_pkg::ST_TRUNC;
      end else begin
        err_code   = tcd_pkg::ST_END;
        s.after_cr = 1'b0;
      end
    end else begin
      unique case (mode)
        tcd_pkg::MODE_RAW: begin
          cand_valid = 1'b1;
          cand_cp    = {13'd0, data_byte};
        end
        tcd_pkg::MODE_UTF8: begin
          if (st.bytes_rem != 2'd0) begin
            if (data_byte[7:6] != 2'b10) begin
              err_valid = 1'b1;
              err_code  = tcd_pkg::ST_BADCONT;
            end else begin
              s.partial   = pv;
              s.bytes_rem = st.bytes_rem - 2'd1;
              if (st.bytes_rem == 2'd1) begin
                if (pv >= 21'h00D800 && pv < 21'h00E000) begin
                  err_valid = 1'b1;
                  err_code  = tcd_pkg::ST_U8SURR;
                end else begin
                  cand_valid = 1'b1;
                  cand_cp    = pv;
                end
              end
            end
          end else if (data_byte == 8'h00) begin
            err_valid = 1'b1;
            err_code  = tcd_pkg::ST_NULL;
          end else if (data_byte >= 8'hF5) begin
            err_valid = 1'b1;
            err_code  = tcd_pkg::ST_HIGHBYTE;
          end else if (data_byte >= 8'hF0) begin
            s.partial   = {18'd0, data_byte[2:0]};
            s.bytes_rem = 2'd3;
          end else if (data_byte >= 8'hE0) begin
            s.partial   = {17'd0, data_byte[3:0]};
            s.bytes_rem = 2'd2;
          end else if (data_byte >= 8'hC2) begin
            s.partial   = {16'd0, data_byte[4:0]};
            s.bytes_rem = 2'd1;
          end else if (data_byte >= 8'h80) begin
            err_valid = 1'b1;
            err_code  = tcd_pkg::ST_BADLEAD;
          end else begin
            cand_valid = 1'b1;
            cand_cp    = {13'd0, data_byte};
          end
        end
        tcd_pkg::MODE_UTF16B, tcd_pkg::MODE_UTF16L: begin
          if (!st.fb_held) begin
            s.fb      = data_byte;
            s.fb_held = 1'b1;
          end else begin
            s.fb_held = 1'b0;
            if (unit[15:10] == 6'b110110) begin
              if (st.hh_pend) begin
                err_valid = 1'b1;
                err_code  = tcd_pkg::ST_TWOHIGH;
              end else begin
                s.hh_pend = 1'b1;
                s.hh_bits = unit[9:0];
              end
            end else if (unit[15:10] == 6'b110111) begin
              if (!st.hh_pend) begin
                err_valid = 1'b1;
                err_code  = tcd_pkg::ST_LONELOW;
              end else begin
                s.hh_pend  = 1'b0;
                cand_valid = 1'b1;
                cand_cp    = 21'h010000 + {1'b0, st.hh_bits, unit[9:0]};
              end
            end else if (st.hh_pend) begin
              err_valid = 1'b1;
              err_code  = tcd_pkg::ST_MISSLOW;
            end else begin
              cand_valid = 1'b1;
              cand_cp    = {5'd0, unit};
            end
          end
        end
        default: begin
          cand_valid = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    st_nxt     = s;
    res_valid  = 1'b0;
    res_cp     = '0;
    res_status = tcd_pkg::ST_CHAR;
    if (err_valid) begin
      res_valid  = 1'b1;
      res_status = err_code;
      if (err_code != tcd_pkg::ST_END) begin
        st_nxt.halted = 1'b1;
      end
    end else if (cand_valid) begin
      st_nxt.after_cr = nres.after_cr;
      res_valid       = nres.emit;
      res_cp          = nres.cp;
      if (nres.is_null) begin
        res_status    = tcd_pkg::ST_NULL;
        st_nxt.halted = 1'b1;
      end
    end
  end

endmodule

### rtl/text_codepoint_decoder.sv
`timescale 1ns / 1ps
// Top level of the text code point decoder: input register, decode state,
// mode register and result register. Depends on tcd_pkg and tcd_decode.
//
// Decodes one byte a cycle as raw 8-bit, UTF-8 or UTF-16 (BE/LE) and gives
// at most one code point or status word per byte. A byte is decoded in one
// pass of logic between the input register and the result register, so the
// block sustains one byte per clock while out_ready is high; the result
// word comes from the result register. A result waiting on out_ready holds
// the byte behind it, and in_ready falls once both registers are full.
// Any error status halts the output until reset; the end status does not.
// Writing the mode (cfg_ready is always high) clears any partly decoded
// character; write it only with no bytes in flight.
module text_codepoint_decoder (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_end_of_stream,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [tcd_pkg::CpW-1:0] out_codepoint,
  output logic [3:0]              out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_encoding_mode
);

  logic                    s1_valid_r, s1_valid_nxt;
  logic [7:0]              s1_byte_r;
  logic                    s1_eos_r;
  logic                    s1_adv;
  tcd_pkg::mode_t          mode_r;
  tcd_pkg::dec_state_t     st_r, st_nxt, dec_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [tcd_pkg::CpW-1:0] out_cp_r;
  tcd_pkg::status_t        out_status_r;
  logic                    res_valid;
  logic [tcd_pkg::CpW-1:0] res_cp;
  tcd_pkg::status_t        res_status;

  tcd_decode u_decode (
    .mode       (mode_r),
    .st         (st_r),
    .data_byte  (s1_byte_r),
    .eos        (s1_eos_r),
    .st_nxt     (dec_nxt),
    .res_valid  (res_valid),
    .res_cp     (res_cp),
    .res_status (res_status)
  );

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_codepoint = out_cp_r;
  assign out_status    = out_status_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    st_nxt = st_r;
    if (cfg_valid) begin
      // drop any partly decoded character, keep CR mark and halt
      st_nxt.bytes_rem = '0;
      st_nxt.partial   = '0;
      st_nxt.fb_held   = 1'b0;
      st_nxt.fb        = '0;
      st_nxt.hh_pend   = 1'b0;
      st_nxt.hh_bits   = '0;
    end else if (s1_adv) begin
      st_nxt = dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= tcd_pkg::MODE_UTF8;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      if (cfg_valid) begin
        mode_r <= tcd_pkg::mode_t'(cfg_encoding_mode);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_eos_r  <= in_end_of_stream;
    end
    if (s1_adv && res_valid) begin
      out_cp_r     <= res_cp;
      out_status_r <= res_status;
    end
  end

endmodule

### dv/text_codepoint_decoder_check.sv
`timescale 1ns / 1ps
// Checker for text_codepoint_decoder: watches the byte, result and mode
// channels, predicts each result word and compares it field by field.
// Depends on tcd_pkg.
module text_codepoint_decoder_check (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_end_of_stream,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [tcd_pkg::CpW-1:0] out_codepoint,
  input  logic [3:0]              out_status,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [1:0]              cfg_encoding_mode,
  output int                      fails,
  output int                      pending,
  output int                      checked
);
  import tcd_pkg::*;

  typedef struct packed {
    logic [CpW-1:0] cp;
    status_t        st;
  } cp_word_t;

  typedef enum int {CP_KEEP, CP_SPACE, CP_DROP} cp_class_t;

  cp_word_t       awaited_words[$];
  cp_word_t       head;
  mode_t          enc_mode;
  logic [1:0]     u8_left;
  logic [CpW-1:0] u8_acc;
  logic           u16_held;
  logic [7:0]     u16_first;
  logic           hi_pend;
  logic [9:0]     hi_bits;
  logic           cr_seen;
  logic           stopped;

  function automatic void clear_partial();
    u8_left   = '0;
    u8_acc    = '0;
    u16_held  = 1'b0;
    u16_first = '0;
    hi_pend   = 1'b0;
    hi_bits   = '0;
  endfunction

  function automatic void post(input logic [CpW-1:0] cp, input status_t st);
    cp_word_t w;
    if (st != ST_CHAR) begin
      cp = '0;
      if (st != ST_END) stopped = 1'b1;
    end
    w.cp = cp;
    w.st = st;
    awaited_words.push_back(w);
  endfunction

  function automatic cp_class_t space_class(input logic [CpW-1:0] cp);
    case (cp)
      21'h0000A0, 21'h001680, 21'h002000, 21'h002001, 21'h002002, 21'h002003,
      21'h002004, 21'h002005, 21'h002006, 21'h002007, 21'h002008, 21'h00202F,
      21'h00205F, 21'h002012, 21'h002013, 21'h002014, 21'h002212, 21'h003000:
        return CP_SPACE;
      21'h0000AD, 21'h002009, 21'h00200A, 21'h00200B, 21'h00200C, 21'h00200D,
      21'h002060, 21'h00FEFF:
        return CP_DROP;
      default:
        return CP_KEEP;
    endcase
  endfunction

  function automatic void normalise_cp(input logic [CpW-1:0] cp);
    if (cp == '0) begin
      post('0, ST_NULL);
      return;
    end
    if (cr_seen) begin
      cr_seen = 1'b0;
      if (cp == 21'h0A) return;
    end
    if (enc_mode != MODE_RAW) begin
      case (space_class(cp))
        CP_DROP: return;
        CP_SPACE: cp = 21'h20;
        default: ;
      endcase
    end
    if (cp == 21'h0D) begin
      cr_seen = 1'b1;
      cp = 21'h0A;
    end
    post(cp, ST_CHAR);
  endfunction

  function automatic void take_utf8(input logic [7:0] b);
    if (u8_left != 0) begin
      if (b[7:6] != 2'b10) begin
        post('0, ST_BADCONT);
        return;
      end
      u8_acc  = {u8_acc[CpW-7:0], b[5:0]};
      u8_left = u8_left - 2'd1;
      if (u8_left != 0) return;
      if (u8_acc >= 21'hD800 && u8_acc < 21'hE000) post('0, ST_U8SURR);
      else normalise_cp(u8_acc);
    end else if (b == 8'h00) begin
      post('0, ST_NULL);
    end else if (b >= 8'hF5) begin
      post('0, ST_HIGHBYTE);
    end else if (b >= 8'hF0) begin
      u8_acc  = {18'd0, b[2:0]};
      u8_left = 2'd3;
    end else if (b >= 8'hE0) begin
      u8_acc  = {17'd0, b[3:0]};
      u8_left = 2'd2;
    end else if (b >= 8'hC2) begin
      u8_acc  = {16'd0, b[4:0]};
      u8_left = 2'd1;
    end else if (b >= 8'h80) begin
      post('0, ST_BADLEAD);
    end else begin
      normalise_cp({13'd0, b});
    end
  endfunction

  function automatic void take_utf16(input logic [7:0] b);
    logic [15:0] unit;
    if (!u16_held) begin
      u16_first = b;
      u16_held  = 1'b1;
      return;
    end
    u16_held = 1'b0;
    unit = (enc_mode == MODE_UTF16B) ? {u16_first, b} : {b, u16_first};
    if (unit >= 16'hD800 && unit < 16'hDC00) begin
      if (hi_pend) begin
        post('0, ST_TWOHIGH);
        return;
      end
      hi_pend = 1'b1;
      hi_bits = unit[9:0];
    end else if (unit >= 16'hDC00 && unit < 16'hE000) begin
      if (!hi_pend) begin
        post('0, ST_LONELOW);
        return;
      end
      hi_pend = 1'b0;
      normalise_cp(21'h10000 + {hi_bits, unit[9:0]});
    end else if (hi_pend) begin
      post('0, ST_MISSLOW);
    end else begin
      normalise_cp({5'd0, unit});
    end
  endfunction

  function automatic void decode_word(input logic [7:0] b, input logic eos);
    if (stopped) return;
    if (eos) begin
      if (u8_left != 0 || u16_held || hi_pend) begin
        post('0, ST_TRUNC);
      end else begin
        cr_seen = 1'b0;
        post('0, ST_END);
      end
      return;
    end
    case (enc_mode)
      MODE_RAW: normalise_cp({13'd0, b});
      MODE_UTF8: take_utf8(b);
      default: take_utf16(b);
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    fails++;
    if (fails <= 10) $display("%s", what);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      enc_mode = MODE_UTF8;
      clear_partial();
      cr_seen = 1'b0;
      stopped = 1'b0;
      awaited_words.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        enc_mode = mode_t'(cfg_encoding_mode);
        clear_partial();
      end
      if (in_valid && in_ready) decode_word(in_data_byte, in_end_of_stream);
      if (out_valid && out_ready) begin
        checked++;
        if (awaited_words.size() == 0) begin
          flag_mismatch($sformatf("unexpected word: codepoint %h status %0d",
                                  out_codepoint, out_status));
        end else begin
          head = awaited_words.pop_front();
          if (out_codepoint !== head.cp || out_status !== head.st)
            flag_mismatch($sformatf(
              "word %0d: expected codepoint %h status %0d, got codepoint %h status %0d",
              checked, head.cp, head.st, out_codepoint, out_status));
        end
      end
    end
    pending = awaited_words.size();
  end

endmodule

### dv/text_codepoint_decoder_test.sv
`timescale 1ns / 1ps
// Test top for text_codepoint_decoder: drives bytes and mode writes, paces
// the result side and gives the verdict. Depends on tcd_pkg, the block and
// text_codepoint_decoder_check.
module text_codepoint_decoder_test;
  import tcd_pkg::*;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [7:0]     in_data_byte = 8'h00;
  logic           in_end_of_stream = 1'b0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [CpW-1:0] out_codepoint;
  logic [3:0]     out_status;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [1:0]     cfg_encoding_mode = MODE_UTF8;

  int      fails;
  int      pending;
  int      checked;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      hold_left = 0;
  int      n_bytes = 0;
  int      k;
  int      chars;
  int      phase_start;
  bit      hold_req = 1'b0;
  mode_t   cur_mode = MODE_UTF8;
  status_t fault;

  text_codepoint_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_stream  (in_end_of_stream),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_codepoint     (out_codepoint),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_encoding_mode (cfg_encoding_mode)
  );

  text_codepoint_decoder_check checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_stream  (in_end_of_stream),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_codepoint     (out_codepoint),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_encoding_mode (cfg_encoding_mode),
    .fails             (fails),
    .pending           (pending),
    .checked           (checked)
  );

  always #10 clk = ~clk;

  // hold off the result side for a long stretch on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("text_codepoint_decoder test failed");
    $finish;
  end

  task automatic put_word(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    n_bytes++;
  endtask

  task automatic put_end();
    put_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic put_utf8(input logic [CpW-1:0] cp, input int n);
    case (n)
      1: put_word(cp[7:0], 1'b0);
      2: begin
        put_word({3'b110, cp[10:6]}, 1'b0);
        put_word({2'b10, cp[5:0]}, 1'b0);
      end
      3: begin
        put_word({4'b1110, cp[15:12]}, 1'b0);
        put_word({2'b10, cp[11:6]}, 1'b0);
        put_word({2'b10, cp[5:0]}, 1'b0);
      end
      default: begin
        put_word({5'b11110, cp[20:18]}, 1'b0);
        put_word({2'b10, cp[17:12]}, 1'b0);
        put_word({2'b10, cp[11:6]}, 1'b0);
        put_word({2'b10, cp[5:0]}, 1'b0);
      end
    endcase
  endtask

  task automatic put_unit16(input logic [15:0] u);
    if (cur_mode == MODE_UTF16B) begin
      put_word(u[15:8], 1'b0);
      put_word(u[7:0], 1'b0);
    end else begin
      put_word(u[7:0], 1'b0);
      put_word(u[15:8], 1'b0);
    end
  endtask

  // drop valid and wait out every awaited word plus the pipeline
  task automatic settle_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    settle_idle();
    cfg_encoding_mode <= m;
    cfg_valid         <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = m;
  endtask

  function automatic logic [CpW-1:0] pick_cp(input bit wide);
    int r;
    logic [CpW-1:0] v;
    r = $urandom_range(99);
    if (r < 30) return CpW'($urandom_range(1, 127));
    if (r < 42) return $urandom_range(1) ? 21'h0D : 21'h0A;
    if (r < 60) begin
      r = $urandom_range(31);
      if (r < 16) return 21'h2000 + CpW'(r);
      case (r)
        16: return 21'h00A0;
        17: return 21'h1680;
        18: return 21'h202F;
        19: return 21'h205F;
        20: return 21'h2010;
        21: return 21'h2012;
        22: return 21'h2013;
        23: return 21'h2014;
        24: return 21'h2015;
        25: return 21'h2212;
        26: return 21'h3000;
        27: return 21'h00AD;
        28: return 21'h2060;
        29: return 21'hFEFF;
        30: return 21'hFEFE;
        default: return 21'h3001;
      endcase
    end
    if (r < 75) return CpW'($urandom_range(21'h80, 21'h7FF));
    if (r < 88) begin
      v = CpW'($urandom_range(21'h800, 21'hF7FF));
      return (v >= 21'hD800) ? v + 21'h800 : v;
    end
    return CpW'($urandom_range(21'h10000, wide ? 21'h13FFFF : 21'h10FFFF));
  endfunction

  task automatic send_char();
    logic [CpW-1:0] cp;
    logic [19:0]    off;
    int             n;
    case (cur_mode)
      MODE_RAW: begin
        cp = CpW'($urandom_range(1, 255));
        if ($urandom_range(99) < 15) cp = $urandom_range(1) ? 21'h0D : 21'h0A;
        put_word(cp[7:0], 1'b0);
      end
      MODE_UTF8: begin
        cp = pick_cp(1'b1);
        n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
        // overlong forms never use a two-byte lead
        if (n < 4 && $urandom_range(9) == 0) n = $urandom_range(4, (n < 3) ? 3 : 4);
        put_utf8(cp, n);
      end
      default: begin
        cp = pick_cp(1'b0);
        if (cp < 21'h10000) begin
          put_unit16(cp[15:0]);
        end else begin
          off = 20'(cp - 21'h10000);
          put_unit16({6'b110110, off[19:10]});
          put_unit16({6'b110111, off[9:0]});
        end
      end
    endcase
    if ($urandom_range(49) == 0) put_end();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_utf8(21'h41, 1);
    put_utf8(21'h80, 2);
    put_utf8(21'h13FFFF, 4);
    put_utf8(21'h41, 3);
    put_utf8(21'h0D, 1);
    put_utf8(21'h0A, 1);
    put_utf8(21'h0D, 1);
    put_utf8(21'hA0, 2);
    put_utf8(21'h200B, 3);
    put_utf8(21'h0D, 1);
    put_end();
    put_utf8(21'h0A, 1);
    put_word(8'hE2, 1'b0);
    set_mode(MODE_RAW);
    put_word(8'hFF, 1'b0);
    put_word(8'h0D, 1'b0);
    set_mode(MODE_UTF16B);
    put_unit16(16'h000A);
    put_unit16(16'hD83D);
    put_unit16(16'hDE00);
    put_word(8'h12, 1'b0);
    set_mode(MODE_UTF16L);
    put_unit16(16'hDBFF);
    put_unit16(16'hDFFF);
    put_end();

    for (k = 0; k < 8; k++) begin
      case (k / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      set_mode(mode_t'(k % 4));
      chars = 0;
      phase_start = n_bytes;
      while (n_bytes - phase_start < 100) begin
        send_char();
        chars++;
        if (k == 1 && chars == 10) hold_req = 1'b1;
        if (k == 5 && chars == 40) settle_idle();
      end
    end

    // close on one malformed stream, then check that the halt holds
    fault = status_t'($urandom_range(ST_NULL, ST_TRUNC));
    case (fault)
      ST_NULL: begin
        set_mode(mode_t'($urandom_range(MODE_RAW, MODE_UTF16L)));
        if (cur_mode == MODE_UTF8 && $urandom_range(1) == 1) put_utf8(21'h0, 3);
        else if (cur_mode >= MODE_UTF16B) put_unit16(16'h0000);
        else put_word(8'h00, 1'b0);
      end
      ST_HIGHBYTE: begin
        set_mode(MODE_UTF8);
        put_word(8'($urandom_range(8'hF5, 8'hFF)), 1'b0);
      end
      ST_BADLEAD: begin
        set_mode(MODE_UTF8);
        put_word(8'($urandom_range(8'h80, 8'hC1)), 1'b0);
      end
      ST_BADCONT: begin
        set_mode(MODE_UTF8);
        put_word(8'($urandom_range(8'hC2, 8'hF4)), 1'b0);
        if ($urandom_range(1) == 1) put_word(8'($urandom_range(8'h00, 8'h7F)), 1'b0);
        else put_word(8'($urandom_range(8'hC0, 8'hFF)), 1'b0);
      end
      ST_U8SURR: begin
        set_mode(MODE_UTF8);
        put_utf8(CpW'($urandom_range(21'hD800, 21'hDFFF)), 3);
      end
      ST_TWOHIGH: begin
        set_mode(mode_t'($urandom_range(MODE_UTF16B, MODE_UTF16L)));
        put_unit16(16'($urandom_range(16'hD800, 16'hDBFF)));
        put_unit16(16'($urandom_range(16'hD800, 16'hDBFF)));
      end
      ST_LONELOW: begin
        set_mode(mode_t'($urandom_range(MODE_UTF16B, MODE_UTF16L)));
        put_unit16(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end
      ST_MISSLOW: begin
        set_mode(mode_t'($urandom_range(MODE_UTF16B, MODE_UTF16L)));
        put_unit16(16'($urandom_range(16'hD800, 16'hDBFF)));
        put_unit16(16'($urandom_range(16'h0001, 16'hD7FF)));
      end
      default: begin
        set_mode(mode_t'($urandom_range(MODE_UTF8, MODE_UTF16L)));
        if (cur_mode == MODE_UTF8) put_word(8'($urandom_range(8'hC2, 8'hF4)), 1'b0);
        else if ($urandom_range(1) == 1) put_word(8'($urandom_range(255)), 1'b0);
        else put_unit16(16'($urandom_range(16'hD800, 16'hDBFF)));
        put_end();
      end
    endcase
    repeat (24) put_word(8'($urandom_range(255)), $urandom_range(3) == 0);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);

    $display("Covered %0d bytes in raw, UTF-8 and both UTF-16 orders under four idle mixes,",
             n_bytes);
    $display("%0d result words checked; stream closed on fault %s", checked, fault.name());
    if (fails == 0) $display("text_codepoint_decoder test passed");
    else $display("text_codepoint_decoder test failed");
    $finish;
  end

endmodule
